@@ hdl/brd_pkg.sv @@
// Shared types and constants for the BMP RLE8/RLE4 span decoder.
// No dependencies; used by the channel interfaces, the top level and the checker.
package brd_pkg;

	localparam int unsigned COLOR_W = 24;
	localparam int unsigned APB_AW  = 4;

	localparam logic [7:0] NIB_MASK = 8'h0F;

	typedef enum logic [1:0] {
		ACT_PALETTE = 2'd0,
		ACT_BYTE    = 2'd1,
		ACT_START   = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		PH_COUNT  = 3'd0,
		PH_VALUE  = 3'd1,
		PH_ESCAPE = 3'd2,
		PH_DX     = 3'd3,
		PH_DY     = 3'd4,
		PH_ABS    = 3'd5,
		PH_PAD    = 3'd6,
		PH_DONE   = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		REG_INDEX_MODE   = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2,
		REG_FLIP_ROWS    = 2'd3
	} reg_idx_t;

	localparam logic [7:0] ESC_EOL   = 8'd0;
	localparam logic [7:0] ESC_EOB   = 8'd1;
	localparam logic [7:0] ESC_DELTA = 8'd2;

endpackage

@@ hdl/brd_ifs.sv @@
// Valid/ready channel interfaces: compressed input beats and decoded span beats.
// Depends on brd_pkg for the colour width.
interface brd_item_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  action;
	logic [7:0]                  palette_index;
	logic [brd_pkg::COLOR_W-1:0] palette_color;
	logic [7:0]                  data_byte;

	modport source (output valid, action, palette_index, palette_color, data_byte,
		input ready);
	modport sink (input valid, action, palette_index, palette_color, data_byte,
		output ready);
endinterface

interface brd_span_if;
	logic                        valid;
	logic                        ready;
	logic [15:0]                 span_x;
	logic [11:0]                 span_row;
	logic [7:0]                  span_length;
	logic [brd_pkg::COLOR_W-1:0] color_even;
	logic [brd_pkg::COLOR_W-1:0] color_odd;
	logic                        outside;
	logic                        image_done;

	modport source (output valid, span_x, span_row, span_length, color_even, color_odd,
		outside, image_done, input ready);
	modport sink (input valid, span_x, span_row, span_length, color_even, color_odd,
		outside, image_done, output ready);
endinterface

@@ hdl/bmp_rle_span_decoder_unit.sv @@
// BMP RLE8/RLE4 span decoder: parser state, palette memory, span result pipeline.
// Depends on brd_pkg and the channel interfaces in brd_ifs.sv.
// Throughput: one input beat per cycle while the output is not stalled; the parser
// updates in the accept cycle and the palette's two read ports are registered into
// stage 1, then into the output register, along with the rest of each span beat.
// Reset: parser and config registers return to their reset values; palette is not cleared.
module bmp_rle_span_decoder_unit #(
	parameter int unsigned PALETTE_ENTRIES = 256,
	parameter int unsigned MAX_DIM         = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	brd_item_if.sink                    in_ch,
	brd_span_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [brd_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int unsigned PAL_AW = $clog2(PALETTE_ENTRIES);
	localparam int unsigned ROW_W  = (MAX_DIM > 4096) ? 13 : 12;
	localparam logic [12:0] HMAX   = (MAX_DIM > 8191) ? 13'd8191 : 13'(MAX_DIM);
	localparam logic [8:0]  PAL_N  = 9'(PALETTE_ENTRIES);

	// configuration registers
	logic        mode_q;
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic        flip_q;

	// parser state
	brd_pkg::phase_t   phase_q, phase_d;
	logic [15:0]       col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [7:0]        held_q, held_d;
	logic [7:0]        abs_left_q, abs_left_d;
	logic              pad_q, pad_d;

	logic [brd_pkg::COLOR_W-1:0] pal_mem [PALETTE_ENTRIES];

	logic        in_acc, in_ready, adv, cfg_wr;
	logic [12:0] effh;
	logic        emit_span, emit_done;
	logic [7:0]  len, add_b, row_inc, idx_e, idx_o;
	logic [16:0] col_sum;
	logic [15:0] col_sat;
	logic [13:0] row_sum;
	logic        row_end;
	logic [12:0] row_ext, frow;
	logic [11:0] span_row;
	logic        outside;

	// stage 1
	logic                        valid_s1;
	logic [15:0]                 x_s1;
	logic [11:0]                 row_s1;
	logic [7:0]                  len_s1;
	logic                        outside_s1, done_s1, zero_e_s1, zero_o_s1;
	logic [brd_pkg::COLOR_W-1:0] rd_e_s1, rd_o_s1;

	// output register
	logic                        out_valid_q;
	logic [15:0]                 x_q;
	logic [11:0]                 row_q_out;
	logic [7:0]                  len_q;
	logic [brd_pkg::COLOR_W-1:0] ce_q, co_q;
	logic                        outside_q, done_q;

	assign adv      = !out_valid_q || out_ch.ready;
	assign in_ready = !valid_s1 || adv;
	assign in_acc   = in_ch.valid && in_ready;
	assign in_ch.ready = in_ready;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b1;
			width_q  <= 13'd4096;
			height_q <= 13'd4096;
			flip_q   <= 1'b1;
		end else if (cfg_wr) begin
			unique case (brd_pkg::reg_idx_t'(paddr[3:2]))
				brd_pkg::REG_INDEX_MODE:   mode_q   <= pwdata[0];
				brd_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[12:0];
				brd_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[12:0];
				brd_pkg::REG_FLIP_ROWS:    flip_q   <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (brd_pkg::reg_idx_t'(paddr[3:2]))
			brd_pkg::REG_INDEX_MODE:   prdata = {31'd0, mode_q};
			brd_pkg::REG_IMAGE_WIDTH:  prdata = {19'd0, width_q};
			brd_pkg::REG_IMAGE_HEIGHT: prdata = {19'd0, height_q};
			brd_pkg::REG_FLIP_ROWS:    prdata = {31'd0, flip_q};
		endcase
	end

	// ---------------- parser ----------------
	always_comb begin
		if (height_q == 13'd0)
			effh = 13'd1;
		else if (height_q > HMAX)
			effh = HMAX;
		else
			effh = height_q;
	end

	always_comb begin
		phase_d    = phase_q;
		col_d      = col_q;
		row_d      = row_q;
		held_d     = held_q;
		abs_left_d = abs_left_q;
		pad_d      = pad_q;
		emit_span  = 1'b0;
		emit_done  = 1'b0;
		len        = 8'd0;
		idx_e      = in_ch.data_byte;
		idx_o      = in_ch.data_byte;

		row_inc = (phase_q == brd_pkg::PH_ESCAPE) ? 8'd1 : in_ch.data_byte;
		row_sum = 14'(row_q) + 14'(row_inc);
		row_end = row_sum >= 14'(effh);

		unique case (phase_q)
			brd_pkg::PH_COUNT: begin
				held_d  = in_ch.data_byte;
				phase_d = (in_ch.data_byte != 8'd0) ? brd_pkg::PH_VALUE : brd_pkg::PH_ESCAPE;
			end
			brd_pkg::PH_VALUE: begin
				phase_d   = brd_pkg::PH_COUNT;
				len       = held_q;
				emit_span = 1'b1;
				if (!mode_q) begin
					idx_e = {4'd0, in_ch.data_byte[7:4]};
					idx_o = in_ch.data_byte & brd_pkg::NIB_MASK;
				end
			end
			brd_pkg::PH_ESCAPE: begin
				priority if (in_ch.data_byte == brd_pkg::ESC_EOL) begin
					col_d = 16'd0;
					if (row_end) begin
						emit_done = 1'b1;
					end else begin
						row_d   = row_sum[ROW_W-1:0];
						phase_d = brd_pkg::PH_COUNT;
					end
				end else if (in_ch.data_byte == brd_pkg::ESC_EOB) begin
					emit_done = 1'b1;
				end else if (in_ch.data_byte == brd_pkg::ESC_DELTA) begin
					phase_d = brd_pkg::PH_DX;
				end else begin
					abs_left_d = in_ch.data_byte;
					pad_d      = 1'b0;
					phase_d    = brd_pkg::PH_ABS;
				end
			end
			brd_pkg::PH_DX: begin
				held_d  = in_ch.data_byte;
				phase_d = brd_pkg::PH_DY;
			end
			brd_pkg::PH_DY: begin
				// column moves even when the move ends the image
				col_d = col_sat;
				if (row_end) begin
					emit_done = 1'b1;
				end else begin
					row_d   = row_sum[ROW_W-1:0];
					phase_d = brd_pkg::PH_COUNT;
				end
			end
			brd_pkg::PH_ABS: begin
				pad_d     = !pad_q;
				emit_span = 1'b1;
				if (mode_q) begin
					len = 8'd1;
				end else if (abs_left_q >= 8'd2) begin
					len   = 8'd2;
					idx_e = {4'd0, in_ch.data_byte[7:4]};
					idx_o = in_ch.data_byte & brd_pkg::NIB_MASK;
				end else begin
					len   = 8'd1;
					idx_e = {4'd0, in_ch.data_byte[7:4]};
					idx_o = {4'd0, in_ch.data_byte[7:4]};
				end
				abs_left_d = (abs_left_q > len) ? (abs_left_q - len) : 8'd0;
				if (abs_left_d == 8'd0)
					phase_d = pad_d ? brd_pkg::PH_PAD : brd_pkg::PH_COUNT;
			end
			brd_pkg::PH_PAD: begin
				pad_d   = 1'b0;
				phase_d = brd_pkg::PH_COUNT;
			end
			brd_pkg::PH_DONE: begin
				// drop bytes until the next start
			end
		endcase

		if (emit_done)
			phase_d = brd_pkg::PH_DONE;
		if (emit_span)
			col_d = col_sat;
	end

	assign add_b   = (phase_q == brd_pkg::PH_DY) ? held_q : len;
	assign col_sum = 17'(col_q) + 17'(add_b);
	assign col_sat = col_sum[16] ? 16'hFFFF : col_sum[15:0];

	assign row_ext  = 13'(row_q);
	assign frow     = effh - 13'd1 - row_ext;
	assign span_row = flip_q ? frow[11:0] : row_ext[11:0];
	assign outside  = (17'(col_q) + 17'(len)) > 17'(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= brd_pkg::PH_COUNT;
			col_q      <= 16'd0;
			row_q      <= '0;
			held_q     <= 8'd0;
			abs_left_q <= 8'd0;
			pad_q      <= 1'b0;
		end else if (in_acc) begin
			if (in_ch.action == brd_pkg::ACT_START) begin
				phase_q    <= brd_pkg::PH_COUNT;
				col_q      <= 16'd0;
				row_q      <= '0;
				held_q     <= 8'd0;
				abs_left_q <= 8'd0;
				pad_q      <= 1'b0;
			end else if (in_ch.action == brd_pkg::ACT_BYTE) begin
				phase_q    <= phase_d;
				col_q      <= col_d;
				row_q      <= row_d;
				held_q     <= held_d;
				abs_left_q <= abs_left_d;
				pad_q      <= pad_d;
			end
		end
	end

	// ---------------- palette memory ----------------
	always_ff @(posedge clk) begin
		if (in_acc && in_ch.action == brd_pkg::ACT_PALETTE
			&& 9'(in_ch.palette_index) < PAL_N)
			pal_mem[in_ch.palette_index[PAL_AW-1:0]] <= in_ch.palette_color;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_e_s1 <= pal_mem[idx_e[PAL_AW-1:0]];
			rd_o_s1 <= pal_mem[idx_o[PAL_AW-1:0]];
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_acc)
			valid_s1 <= (in_ch.action == brd_pkg::ACT_BYTE) && (emit_span || emit_done);
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1       <= emit_done ? 16'd0 : col_q;
			row_s1     <= emit_done ? 12'd0 : span_row;
			len_s1     <= emit_done ? 8'd0 : len;
			outside_s1 <= emit_done ? 1'b0 : outside;
			done_s1    <= emit_done;
			zero_e_s1  <= emit_done || (9'(idx_e) >= PAL_N);
			zero_o_s1  <= emit_done || (9'(idx_o) >= PAL_N);
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			x_q       <= x_s1;
			row_q_out <= row_s1;
			len_q     <= len_s1;
			ce_q      <= zero_e_s1 ? '0 : rd_e_s1;
			co_q      <= zero_o_s1 ? '0 : rd_o_s1;
			outside_q <= outside_s1;
			done_q    <= done_s1;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.span_x      = x_q;
	assign out_ch.span_row    = row_q_out;
	assign out_ch.span_length = len_q;
	assign out_ch.color_even  = ce_q;
	assign out_ch.color_odd   = co_q;
	assign out_ch.outside     = outside_q;
	assign out_ch.image_done  = done_q;

endmodule

@@ hdl/brd_sva.sv @@
// Port-level checks on the span output of the decoder, bound to the top level.
// Depends on brd_pkg for the colour width.
module brd_sva (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [15:0]                 span_x,
	input logic [11:0]                 span_row,
	input logic [7:0]                  span_length,
	input logic [brd_pkg::COLOR_W-1:0] color_even,
	input logic [brd_pkg::COLOR_W-1:0] color_odd,
	input logic                        outside,
	input logic                        image_done
);

	// hold a stalled span beat
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(span_x) && $stable(span_length)
			&& $stable(color_even) && $stable(image_done))
		else $error("span beat changed while stalled");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> span_x == 16'd0 && span_row == 12'd0
			&& span_length == 8'd0 && color_even == '0 && color_odd == '0 && !outside)
		else $error("image-done marker carries nonzero fields");

	a_span_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !image_done |-> span_length != 8'd0)
		else $error("pixel span of zero length");

endmodule

bind bmp_rle_span_decoder_unit brd_sva u_brd_sva (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.span_x      (out_ch.span_x),
	.span_row    (out_ch.span_row),
	.span_length (out_ch.span_length),
	.color_even  (out_ch.color_even),
	.color_odd   (out_ch.color_odd),
	.outside     (out_ch.outside),
	.image_done  (out_ch.image_done)
);
